[sv/assert_macros.svh]
// Assertion macros shared by the generator RTL.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/mtg_pkg.sv]
// Constants, types and tempering function for the MT19937 generator.
// No dependencies.
package mtg_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int WRAP_BACK    = STATE_WORDS - TWIST_OFFSET;
   localparam int ADDR_W       = $clog2(STATE_WORDS);
   localparam int IDX_W        = $clog2(STATE_WORDS + 2);

   typedef logic [31:0]       word_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam word_type TWIST_MATRIX = 32'h9908b0df;
   localparam word_type HIGH_BIT     = 32'h80000000;
   localparam word_type LOW_BITS     = 32'h7fffffff;
   localparam word_type TEMPER_B     = 32'h9d2c5680;
   localparam word_type TEMPER_C     = 32'hefc60000;
   localparam word_type SEED_MULT    = 32'd69069;
   localparam word_type DEFAULT_SEED = 32'd4357;

   localparam addr_type LAST_ADDR  = ADDR_W'(STATE_WORDS - 1);
   localparam idx_type  IDX_SEEDED = IDX_W'(STATE_WORDS);
   localparam idx_type  IDX_NEVER  = IDX_W'(STATE_WORDS + 1);

   localparam logic CMD_NEXT = 1'b0;
   localparam logic CMD_SEED = 1'b1;

   function automatic word_type temper(input word_type y_in);
      word_type y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

[sv/mersenne_twister_generator.sv]
// MT19937 generator: 624-word state RAM with one read and one write port.
// Depends on mtg_pkg and assert_macros.svh.
//
// A next transaction (req_tuser 0) returns one tempered word on the rsp channel;
// a seed transaction (req_tuser 1) reloads the state from req_tdata and returns
// nothing. The state RAM has a single read port, so for a next the words i, i+1
// and i+397 are fetched in turn before word i is rewritten and tempered. A seed
// makes one RAM write per state word through a 32x17 multiplier. A next issued
// before any seed first seeds with 4357. A result waiting on rsp holds only the
// final write-back stage; a new transaction is taken meanwhile.
module mersenne_twister_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  mtg_pkg::word_type  req_tdata,   // [31:0] seed_value
   input  logic               req_tuser,   // [0] cmd
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output mtg_pkg::word_type  rsp_tdata    // [31:0] random_word
);
   import mtg_pkg::*;
`include "assert_macros.svh"

   typedef enum logic [2:0] {IDLE, SEED, RD_N, RD_F, TWIST} state_type;

   state_type state_ff, state_in;
   idx_type   idx_ff, idx_in;
   addr_type  cur_ff, cur_in;
   addr_type  seed_addr_ff, seed_addr_in;
   word_type  seed_word_ff, seed_word_in;
   logic      pending_ff, pending_in;
   word_type  word_i_ff, word_i_in;
   word_type  y_ff, y_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   word_type  rsp_tdata_ff, rsp_tdata_in;

   word_type  mem [STATE_WORDS];
   word_type  rd_data_ff;
   logic      rd_en;
   addr_type  rd_addr;
   logic      mem_we;
   addr_type  mem_waddr;
   word_type  mem_wdata;

   logic      accept;
   logic      slot_free;
   addr_type  nxt_addr;
   addr_type  far_addr;
   addr_type  start_addr;
   word_type  twisted;
   word_type  seed_prod;

   assign req_tready = (state_ff == IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign nxt_addr   = (cur_ff == LAST_ADDR) ? '0 : cur_ff + 1'b1;
   assign far_addr   = (cur_ff < ADDR_W'(WRAP_BACK)) ? cur_ff + ADDR_W'(TWIST_OFFSET)
                                                     : cur_ff - ADDR_W'(WRAP_BACK);
   assign start_addr = (idx_ff >= IDX_SEEDED) ? '0 : idx_ff[ADDR_W-1:0];
   assign twisted    = rd_data_ff ^ (y_ff >> 1) ^ (y_ff[0] ? TWIST_MATRIX : '0);
   assign seed_prod  = seed_word_ff * SEED_MULT;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      seed_addr_in  = seed_addr_ff;
      seed_word_in  = seed_word_ff;
      pending_in    = pending_ff;
      word_i_in     = word_i_ff;
      y_in          = y_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff;
      mem_wdata     = twisted;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               if (req_tuser == CMD_SEED) begin
                  seed_word_in = req_tdata;
                  seed_addr_in = '0;
                  pending_in   = 1'b0;
                  state_in     = SEED;
               end else if (idx_ff == IDX_NEVER) begin
                  seed_word_in = DEFAULT_SEED;
                  seed_addr_in = '0;
                  pending_in   = 1'b1;
                  state_in     = SEED;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = start_addr;
                  cur_in   = start_addr;
                  state_in = RD_N;
               end
            end
         end
         SEED: begin
            mem_we       = 1'b1;
            mem_waddr    = seed_addr_ff;
            mem_wdata    = seed_word_ff;
            seed_word_in = seed_prod;
            if (seed_addr_ff == LAST_ADDR) begin
               idx_in = IDX_SEEDED;
               if (pending_ff) begin
                  pending_in = 1'b0;
                  rd_en      = 1'b1;
                  rd_addr    = '0;
                  cur_in     = '0;
                  state_in   = RD_N;
               end else begin
                  state_in = IDLE;
               end
            end else begin
               seed_addr_in = seed_addr_ff + 1'b1;
            end
         end
         RD_N: begin
            word_i_in = rd_data_ff;
            rd_en     = 1'b1;
            rd_addr   = nxt_addr;
            state_in  = RD_F;
         end
         RD_F: begin
            y_in     = (word_i_ff & HIGH_BIT) | (rd_data_ff & LOW_BITS);
            rd_en    = 1'b1;
            rd_addr  = far_addr;
            state_in = TWIST;
         end
         TWIST: begin
            if (slot_free) begin
               mem_we        = 1'b1;
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = temper(twisted);
               idx_in        = IDX_W'(cur_ff) + 1'b1;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         idx_ff        <= IDX_NEVER;
         pending_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pending_ff    <= pending_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cur_ff       <= cur_in;
      seed_addr_ff <= seed_addr_in;
      seed_word_ff <= seed_word_in;
      word_i_ff    <= word_i_in;
      y_ff         <= y_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   `ASSERT_NEXT(a_seed_walks, accept && (req_tuser == CMD_SEED), state_ff == SEED, "seed transaction did not start the seeding walk")
   `ASSERT_NEXT(a_seed_done, (state_ff == SEED) && (seed_addr_ff == LAST_ADDR), idx_ff == IDX_SEEDED, "read index not reset after seeding")
   `ASSERT_IMPLIES(a_rsp_from_twist, !reset && $rose(rsp_tvalid_ff), $past(state_ff == TWIST), "result raised outside write-back")
   `ASSERT_IMPLIES(a_twist_addr, mem_we && (state_ff == TWIST), idx_type'(cur_ff) < IDX_SEEDED, "refresh write outside the state words")

endmodule

[tb/mersenne_twister_generator_tb.sv]
// Self-checking testbench for mersenne_twister_generator: directed and random seed/next
// transactions are checked against an in-bench MT19937 predictor.
// Depends on mtg_pkg and the generator RTL.
`timescale 1ns / 100ps

module mersenne_twister_generator_tb;
   import mtg_pkg::*;

   localparam int RANDOM_ITEMS   = 720;
   localparam int SEEDLESS_RUN   = 650;   // long next run so the read index wraps
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 700;   // covers a seed in flight
   localparam int CYCLE_LIMIT    = 300000;
   localparam int DIRECTED_ROWS  = 21;

   typedef struct packed {
      logic     cmd;
      word_type seed;
      logic     has_word;
      word_type word;
   } stim_row_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_tvalid;
   logic     req_tready;
   word_type req_tdata;     // [31:0] seed_value
   logic     req_tuser;     // [0] cmd
   logic     rsp_tvalid;
   logic     rsp_tready;
   word_type rsp_tdata;     // [31:0] random_word

   word_type  twist_state [STATE_WORDS];
   int        draw_pos;
   word_type  pending_words [$];
   int        fail_count;
   int        cycle_count;
   int        sender_idle_pct;
   int        sink_idle_pct;
   logic      long_hold_armed;
   logic      long_hold_taken;
   int        stall_left;
   stim_row_type directed_rows [DIRECTED_ROWS];

   mersenne_twister_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // ---- predictor ----

   function automatic void load_words(input word_type seed);
      twist_state[0] = seed;
      for (int i = 1; i < STATE_WORDS; i++) begin
         twist_state[i] = twist_state[i-1] * SEED_MULT;
      end
      draw_pos = STATE_WORDS;
   endfunction

   function automatic word_type shape_word(input word_type w);
      word_type t;
      t = w ^ {11'd0, w[31:11]};
      t = t ^ ({t[24:0], 7'd0} & TEMPER_B);
      t = t ^ ({t[16:0], 15'd0} & TEMPER_C);
      return t ^ {18'd0, t[31:18]};
   endfunction

   function automatic word_type draw_word();
      int       nxt;
      int       far;
      word_type y;
      word_type mixed;
      if (draw_pos >= STATE_WORDS) begin
         if (draw_pos == STATE_WORDS + 1) begin
            load_words(DEFAULT_SEED);
         end
         draw_pos = 0;
      end
      nxt   = (draw_pos + 1) % STATE_WORDS;
      far   = (draw_pos + TWIST_OFFSET) % STATE_WORDS;
      y     = {twist_state[draw_pos][31], twist_state[nxt][30:0]};
      mixed = twist_state[far] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'h0);
      twist_state[draw_pos] = mixed;
      draw_pos++;
      return shape_word(mixed);
   endfunction

   // ---- request side ----

   task automatic push_item(input logic cmd, input word_type seed,
                            input logic has_word, input word_type word);
      word_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= seed;
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_SEED) begin
         load_words(seed);
      end else begin
         predicted = draw_word();
         pending_words.push_back(has_word ? word : predicted);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // ---- response side ----

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_armed && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            stall_left      = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("random_word: no transaction expected, got %h", rsp_tdata);
            fail_count++;
         end else if (rsp_tdata !== pending_words[0]) begin
            $error("random_word: expected %h, got %h", pending_words[0], rsp_tdata);
            fail_count++;
            void'(pending_words.pop_front());
         end else begin
            void'(pending_words.pop_front());
         end
      end
   end

   // ---- watchdog ----

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL mersenne_twister_generator");
      $finish;
   end

   // ---- stimulus ----

   initial begin
      logic     cmd;
      word_type seed;

      req_tvalid      <= 1'b0;
      req_tuser       <= CMD_NEXT;
      req_tdata       <= '0;
      fail_count      = 0;
      stall_left      = 0;
      long_hold_armed = 1'b0;
      long_hold_taken = 1'b0;
      sender_idle_pct = 19;
      sink_idle_pct   = 45;
      draw_pos        = STATE_WORDS + 1;
      for (int i = 0; i < STATE_WORDS; i++) twist_state[i] = '0;

      directed_rows = '{
         // next before any seed: self-seeds with the default
         '{CMD_NEXT, 32'hffffffff,   1'b0, 32'h0},
         '{CMD_NEXT, 32'h00000000,   1'b0, 32'h0},
         '{CMD_NEXT, 32'haaaaaaaa,   1'b0, 32'h0},
         // zero seed: every word stays zero
         '{CMD_SEED, 32'h00000000,   1'b0, 32'h0},
         '{CMD_NEXT, 32'h00000000,   1'b1, 32'h0},
         '{CMD_NEXT, 32'hffffffff,   1'b1, 32'h0},
         '{CMD_NEXT, 32'h55555555,   1'b1, 32'h0},
         '{CMD_SEED, 32'hffffffff,   1'b0, 32'h0},
         '{CMD_NEXT, 32'h00000000,   1'b0, 32'h0},
         '{CMD_NEXT, 32'h00000000,   1'b0, 32'h0},
         '{CMD_SEED, HIGH_BIT,       1'b0, 32'h0},
         '{CMD_NEXT, 32'hffffffff,   1'b0, 32'h0},
         '{CMD_SEED, 32'h00000001,   1'b0, 32'h0},
         '{CMD_NEXT, 32'h00000000,   1'b0, 32'h0},
         '{CMD_SEED, DEFAULT_SEED,   1'b0, 32'h0},
         '{CMD_NEXT, 32'h00000000,   1'b0, 32'h0},
         '{CMD_NEXT, 32'hffffffff,   1'b0, 32'h0},
         // back-to-back seeds: only the second counts
         '{CMD_SEED, LOW_BITS,       1'b0, 32'h0},
         '{CMD_SEED, 32'h12345678,   1'b0, 32'h0},
         '{CMD_NEXT, 32'h00000000,   1'b0, 32'h0},
         '{CMD_NEXT, 32'hffffffff,   1'b0, 32'h0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         push_item(directed_rows[r].cmd, directed_rows[r].seed,
                   directed_rows[r].has_word, directed_rows[r].word);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            drain_results();
            sender_idle_pct <= 45;
            sink_idle_pct   <= 19;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            drain_results();
            sender_idle_pct <= 0;
            sink_idle_pct   <= 0;
            long_hold_armed <= 1'b1;
         end
         cmd  = (n >= SEEDLESS_RUN && $urandom_range(11) == 0) ? CMD_SEED : CMD_NEXT;
         seed = $urandom;
         push_item(cmd, seed, 1'b0, 32'h0);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS mersenne_twister_generator");
      end else begin
         $display("FAIL mersenne_twister_generator");
      end
      $finish;
   end

endmodule

[mersenne_twister_generator.f]
+incdir+sv
sv/mtg_pkg.sv
sv/mersenne_twister_generator.sv
tb/mersenne_twister_generator_tb.sv
